// File: rtl/timestamp_stream_pairing_macros.svh
// assertion macros for the timestamp stream pairing block
`ifndef TIMESTAMP_STREAM_PAIRING_MACROS_SVH
`define TIMESTAMP_STREAM_PAIRING_MACROS_SVH
`ifndef SYNTHESIS
`define TSP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define TSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define TSP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define TSP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/tsp_pkg.sv
// shared constants and types of the timestamp stream pairing block
package tsp_pkg;

   localparam int MAX_RESULTS   = 16;
   localparam int CSR_ADDR_BITS = 5;

   // register indexes
   localparam logic [2:0] REG_PHASE_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_FRAME_INTERVAL  = 3'd1;
   localparam logic [2:0] REG_DRIFT_SHIFT     = 3'd2;
   localparam logic [2:0] REG_MIN_SAMPLES     = 3'd3;
   localparam logic [2:0] REG_LEAD_CAP        = 3'd4;

   // reset values
   localparam logic [31:0] RST_PHASE_THRESHOLD = 32'd0;
   localparam logic [19:0] RST_FRAME_INTERVAL  = 20'd33333;
   localparam logic [4:0]  RST_DRIFT_SHIFT     = 5'd5;
   localparam logic [4:0]  RST_MIN_SAMPLES     = 5'd3;
   localparam logic [4:0]  RST_LEAD_CAP        = 5'd8;

   typedef struct packed {
      logic [31:0] phase_threshold;
      logic [19:0] frame_interval;
      logic [4:0]  drift_shift;
      logic [4:0]  min_samples;
      logic [4:0]  lead_cap;
   } cfg_type;

endpackage

// File: rtl/tsp_front.sv
// input front: accepts beats, folds the kind-specific field and queues them
module tsp_front import tsp_pkg::*; #(
   parameter int TIME_BITS = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic                 in_op,
   input  logic [TIME_BITS-1:0] in_device,
   input  logic [TIME_BITS-1:0] in_depth,
   input  logic [TIME_BITS-1:0] in_end,
   input  logic [TIME_BITS-1:0] in_host,
   input  logic [31:0]          in_tag,
   output logic                 q_valid,
   input  logic                 q_ready,
   output logic                 q_op,
   output logic [TIME_BITS-1:0] q_device,
   output logic [TIME_BITS-1:0] q_aux,
   output logic [TIME_BITS-1:0] q_host,
   output logic [31:0]          q_tag
);

   localparam int EW = 1 + 3 * TIME_BITS + 32;

   logic [EW-1:0] slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          push, pop;
   logic [TIME_BITS-1:0] aux;
   logic [EW-1:0] head;

   // frames keep their depth time, slices their end time
   assign aux      = in_op ? in_end : in_depth;
   assign in_ready = (count_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (count_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign head     = slot_ff[rd_ptr_ff];

   assign q_device = head[TIME_BITS-1:0];
   assign q_aux    = head[2*TIME_BITS-1:TIME_BITS];
   assign q_host   = head[3*TIME_BITS-1:2*TIME_BITS];
   assign q_tag    = head[3*TIME_BITS+31:3*TIME_BITS];
   assign q_op     = head[EW-1];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= {in_op, in_tag, in_host, aux, in_device};
      end
   end

endmodule

// File: rtl/tsp_engine.sv
// back end: the two rings, bootstrap alignment, nearest-slice pairing and result register
`include "timestamp_stream_pairing_macros.svh"
module tsp_engine import tsp_pkg::*; #(
   parameter int RING_DEPTH = 16,
   parameter int TIME_BITS  = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  logic                 q_op,
   input  logic [TIME_BITS-1:0] q_device,
   input  logic [TIME_BITS-1:0] q_aux,
   input  logic [TIME_BITS-1:0] q_host,
   input  logic [31:0]          q_tag,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [96+3*TIME_BITS+4*(TIME_BITS+2)-1:0] out_data,
   output logic                 out_skip,
   output logic                 out_last
);

   localparam int T   = TIME_BITS;
   localparam int OW  = T + 2;
   localparam int CW  = T + 4;
   localparam int IW  = $clog2(RING_DEPTH);
   localparam int FW  = $clog2(RING_DEPTH + 1);
   localparam int LW  = (FW > 5) ? FW : 5;
   localparam int NW  = $clog2(MAX_RESULTS + 1);
   localparam int EW  = 3 * T + 32;
   localparam int PDW = 96 + 3 * T + 4 * OW;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_BOOT_RD  = 4'd1;
   localparam logic [3:0] S_BOOT_EV  = 4'd2;
   localparam logic [3:0] S_BOOT_RD2 = 4'd3;
   localparam logic [3:0] S_BOOT_SET = 4'd4;
   localparam logic [3:0] S_P_START  = 4'd5;
   localparam logic [3:0] S_P_HEAD   = 4'd6;
   localparam logic [3:0] S_P_D0     = 4'd7;
   localparam logic [3:0] S_SCAN     = 4'd8;
   localparam logic [3:0] S_DECIDE   = 4'd9;
   localparam logic [3:0] S_EMIT     = 4'd10;
   localparam logic [3:0] S_FINISH   = 4'd11;

   function automatic logic [IW-1:0] idx_add(input logic [IW-1:0] base,
                                              input logic [FW-1:0] cnt);
      logic [FW:0] sum;
      sum = (FW+1)'(base) + (FW+1)'(cnt);
      if (sum >= (FW+1)'(RING_DEPTH)) begin
         sum = sum - (FW+1)'(RING_DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   // ring memories, one registered read each
   logic [EW-1:0] frame_mem [RING_DEPTH];
   logic [EW-1:0] slice_mem [RING_DEPTH];
   logic [EW-1:0] frame_rd_ff, slice_rd_ff;
   logic [IW-1:0] frame_raddr, slice_raddr, frame_waddr, slice_waddr;
   logic          frame_we, slice_we;
   logic [EW-1:0] wdata;

   // control state
   logic [3:0]    state_ff, state_in;
   logic [IW-1:0] frame_head_ff, frame_head_in, slice_head_ff, slice_head_in;
   logic [FW-1:0] frame_fill_ff, frame_fill_in, slice_fill_ff, slice_fill_in;
   logic          aligned_ff, aligned_in;
   logic [OW-1:0] offset_ff, offset_in;
   logic          skip_ff, skip_in;
   logic [31:0]   pair_count_ff, pair_count_in;
   logic [NW-1:0] n_ff, n_in;
   logic          pend_valid_ff, pend_valid_in;
   logic          out_valid_ff, out_valid_in;

   // working payload
   logic [IW-1:0] sptr_ff, sptr_in;
   logic [FW-1:0] i_ff, i_in, best_ff, best_in;
   logic [CW-1:0] mapped_ff, mapped_in, best_diff_ff, best_diff_in, best_nd_ff, best_nd_in;
   logic [CW-1:0] step_ff, step_in;
   logic [T-1:0]  best_start_ff, best_start_in, best_end_ff, best_end_in;
   logic [31:0]   best_tag_ff, best_tag_in;
   logic [PDW-1:0] pend_data_ff, pend_data_in, out_data_ff, out_data_in;
   logic          pend_skip_ff, pend_skip_in, out_skip_ff, out_skip_in;
   logic          out_last_ff, out_last_in;

   logic [T-1:0]  f_time, f_depth, f_host, s_start, s_end, s_host;
   logic [31:0]   f_tag, s_tag;
   logic [CW-1:0] off_c, mapped_calc, depth_map, s_start_c, sc_diff, sc_nd, best_abs;
   logic [CW-1:0] lead_lim, mag_sh, step_calc, new_off;
   logic          lt, brk_ahead, out_free, emit_go;
   logic          f_pos, s_pos, skip_due, fill_ok;
   logic [T:0]    phase, thr_ext, boot_diff;
   logic [LW-1:0] need;
   logic [FW-1:0] slice_pop_cnt;
   logic [IW-1:0] sptr_next;

   assign f_time  = frame_rd_ff[T-1:0];
   assign f_depth = frame_rd_ff[2*T-1:T];
   assign f_host  = frame_rd_ff[3*T-1:2*T];
   assign f_tag   = frame_rd_ff[3*T+31:3*T];
   assign s_start = slice_rd_ff[T-1:0];
   assign s_end   = slice_rd_ff[2*T-1:T];
   assign s_host  = slice_rd_ff[3*T-1:2*T];
   assign s_tag   = slice_rd_ff[3*T+31:3*T];

   assign off_c       = {{(CW-OW){offset_ff[OW-1]}}, offset_ff};
   assign mapped_calc = {{(CW-T){1'b0}}, f_time} + off_c;
   assign depth_map   = {{(CW-T){1'b0}}, f_depth} + off_c;
   assign s_start_c   = {{(CW-T){1'b0}}, s_start};
   assign sc_diff     = s_start_c - mapped_ff;
   assign sc_nd       = mapped_ff - s_start_c;
   assign best_abs    = best_diff_ff[CW-1] ? best_nd_ff : best_diff_ff;
   // strictly closer than the best so far, both magnitudes non-negative
   assign lt          = sc_diff[CW-1] ? (sc_nd < best_abs) : (sc_diff < best_abs);
   assign lead_lim    = mapped_ff + CW'(cfg.frame_interval);
   assign brk_ahead   = $signed({{(CW-T){1'b0}}, best_start_ff}) > $signed(lead_lim);
   // drift step rounded toward zero
   assign mag_sh      = best_abs >> cfg.drift_shift;
   assign step_calc   = best_diff_ff[CW-1] ? (~mag_sh + CW'(1)) : mag_sh;
   assign new_off     = off_c + step_ff;

   assign f_pos     = !f_host[T-1] && (|f_host);
   assign s_pos     = !s_host[T-1] && (|s_host);
   assign phase     = {f_host[T-1], f_host} - {s_host[T-1], s_host};
   assign thr_ext   = {{(T-31){cfg.phase_threshold[31]}}, cfg.phase_threshold};
   assign skip_due  = $signed(phase) < $signed(thr_ext);
   assign boot_diff = {1'b0, s_start} - {1'b0, f_time};
   assign need      = (cfg.min_samples == 5'd0) ? LW'(1) : LW'(cfg.min_samples);
   assign fill_ok   = (LW'(frame_fill_ff) >= need) && (LW'(slice_fill_ff) >= need);

   assign out_free      = !out_valid_ff || out_ready;
   assign emit_go       = !pend_valid_ff || out_free;
   assign slice_pop_cnt = best_ff + FW'(1);
   assign sptr_next     = idx_add(sptr_ff, FW'(1));
   assign q_ready       = (state_ff == S_IDLE);
   assign wdata         = {q_tag, q_host, q_aux, q_device};

   always_comb begin
      state_in      = state_ff;
      frame_head_in = frame_head_ff;
      frame_fill_in = frame_fill_ff;
      slice_head_in = slice_head_ff;
      slice_fill_in = slice_fill_ff;
      aligned_in    = aligned_ff;
      offset_in     = offset_ff;
      skip_in       = skip_ff;
      pair_count_in = pair_count_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      out_valid_in  = out_valid_ff && !out_ready;
      sptr_in       = sptr_ff;
      i_in          = i_ff;
      best_in       = best_ff;
      mapped_in     = mapped_ff;
      best_diff_in  = best_diff_ff;
      best_nd_in    = best_nd_ff;
      step_in       = step_ff;
      best_start_in = best_start_ff;
      best_end_in   = best_end_ff;
      best_tag_in   = best_tag_ff;
      pend_data_in  = pend_data_ff;
      pend_skip_in  = pend_skip_ff;
      out_data_in   = out_data_ff;
      out_skip_in   = out_skip_ff;
      out_last_in   = out_last_ff;
      frame_raddr   = frame_head_ff;
      slice_raddr   = slice_head_ff;
      frame_we      = 1'b0;
      slice_we      = 1'b0;
      frame_waddr   = idx_add(frame_head_ff, frame_fill_ff);
      slice_waddr   = idx_add(slice_head_ff, slice_fill_ff);

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               n_in = '0;
               if (!q_op) begin
                  frame_we = 1'b1;
                  if (frame_fill_ff == FW'(RING_DEPTH)) begin
                     // full ring: overwrite the oldest entry
                     frame_waddr   = frame_head_ff;
                     frame_head_in = idx_add(frame_head_ff, FW'(1));
                  end else begin
                     frame_fill_in = frame_fill_ff + FW'(1);
                  end
               end else begin
                  slice_we = 1'b1;
                  if (slice_fill_ff == FW'(RING_DEPTH)) begin
                     slice_waddr   = slice_head_ff;
                     slice_head_in = idx_add(slice_head_ff, FW'(1));
                  end else begin
                     slice_fill_in = slice_fill_ff + FW'(1);
                  end
               end
               state_in = aligned_ff ? S_P_START : S_BOOT_RD;
            end
         end
         S_BOOT_RD: begin
            state_in = fill_ok ? S_BOOT_EV : S_IDLE;
         end
         S_BOOT_EV: begin
            if (!(f_pos && s_pos)) begin
               state_in = S_IDLE;
            end else if (skip_due) begin
               if (frame_fill_ff < FW'(2)) begin
                  state_in = S_IDLE;
               end else begin
                  frame_head_in = idx_add(frame_head_ff, FW'(1));
                  frame_fill_in = frame_fill_ff - FW'(1);
                  skip_in       = 1'b1;
                  state_in      = S_BOOT_RD2;
               end
            end else begin
               skip_in    = 1'b0;
               offset_in  = {{(OW-T-1){boot_diff[T]}}, boot_diff};
               aligned_in = 1'b1;
               state_in   = S_P_START;
            end
         end
         S_BOOT_RD2: begin
            state_in = S_BOOT_SET;
         end
         S_BOOT_SET: begin
            offset_in  = {{(OW-T-1){boot_diff[T]}}, boot_diff};
            aligned_in = 1'b1;
            state_in   = S_P_START;
         end
         S_P_START: begin
            sptr_in = slice_head_ff;
            if ((frame_fill_ff == '0) || (slice_fill_ff == '0) ||
                (n_ff == NW'(MAX_RESULTS))) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_P_HEAD;
            end
         end
         S_P_HEAD: begin
            mapped_in     = mapped_calc;
            best_start_in = s_start;
            best_end_in   = s_end;
            best_tag_in   = s_tag;
            best_in       = '0;
            state_in      = S_P_D0;
         end
         S_P_D0: begin
            best_diff_in = sc_diff;
            best_nd_in   = sc_nd;
            slice_raddr  = sptr_next;
            sptr_in      = sptr_next;
            i_in         = FW'(1);
            state_in     = (slice_fill_ff > FW'(1)) ? S_SCAN : S_DECIDE;
         end
         S_SCAN: begin
            slice_raddr = sptr_next;
            sptr_in     = sptr_next;
            state_in    = S_DECIDE;
            if (lt) begin
               best_in       = i_ff;
               best_diff_in  = sc_diff;
               best_nd_in    = sc_nd;
               best_start_in = s_start;
               best_end_in   = s_end;
               best_tag_in   = s_tag;
               if ((i_ff + FW'(1)) < slice_fill_ff) begin
                  i_in     = i_ff + FW'(1);
                  state_in = S_SCAN;
               end
            end
         end
         S_DECIDE: begin
            // best is the newest slice and still ahead: wait for more slices
            if ((best_ff == slice_fill_ff - FW'(1)) && brk_ahead) begin
               state_in = S_FINISH;
            end else begin
               step_in  = step_calc;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit_go) begin
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_data_in  = pend_data_ff;
                  out_skip_in  = pend_skip_ff;
                  out_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_skip_in  = skip_ff;
               pend_data_in  = {pair_count_ff, depth_map[OW-1:0], mapped_ff[OW-1:0],
                                offset_ff, best_diff_ff[OW-1:0], best_end_ff,
                                best_start_ff, f_time, best_tag_ff, f_tag};
               offset_in     = new_off[OW-1:0];
               pair_count_in = pair_count_ff + 32'd1;
               n_in          = n_ff + NW'(1);
               slice_head_in = idx_add(slice_head_ff, slice_pop_cnt);
               slice_fill_in = slice_fill_ff - slice_pop_cnt;
               frame_head_in = idx_add(frame_head_ff, FW'(1));
               frame_fill_in = frame_fill_ff - FW'(1);
               state_in      = S_P_START;
            end
         end
         S_FINISH: begin
            if (emit_go) begin
               if (pend_valid_ff) begin
                  out_valid_in  = 1'b1;
                  out_data_in   = pend_data_ff;
                  out_skip_in   = pend_skip_ff;
                  out_last_in   = 1'b1;
                  pend_valid_in = 1'b0;
               end
               // stall guard
               if ((LW'(frame_fill_ff) > LW'(cfg.lead_cap)) && (slice_fill_ff == '0)) begin
                  frame_head_in = idx_add(frame_head_ff, FW'(1));
                  frame_fill_in = frame_fill_ff - FW'(1);
               end else if ((LW'(slice_fill_ff) > LW'(cfg.lead_cap)) &&
                            (frame_fill_ff == '0)) begin
                  slice_head_in = idx_add(slice_head_ff, FW'(1));
                  slice_fill_in = slice_fill_ff - FW'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         frame_head_ff <= '0;
         frame_fill_ff <= '0;
         slice_head_ff <= '0;
         slice_fill_ff <= '0;
         aligned_ff    <= 1'b0;
         offset_ff     <= '0;
         skip_ff       <= 1'b0;
         pair_count_ff <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         frame_head_ff <= frame_head_in;
         frame_fill_ff <= frame_fill_in;
         slice_head_ff <= slice_head_in;
         slice_fill_ff <= slice_fill_in;
         aligned_ff    <= aligned_in;
         offset_ff     <= offset_in;
         skip_ff       <= skip_in;
         pair_count_ff <= pair_count_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sptr_ff       <= sptr_in;
      i_ff          <= i_in;
      best_ff       <= best_in;
      mapped_ff     <= mapped_in;
      best_diff_ff  <= best_diff_in;
      best_nd_ff    <= best_nd_in;
      step_ff       <= step_in;
      best_start_ff <= best_start_in;
      best_end_ff   <= best_end_in;
      best_tag_ff   <= best_tag_in;
      pend_data_ff  <= pend_data_in;
      pend_skip_ff  <= pend_skip_in;
      out_data_ff   <= out_data_in;
      out_skip_ff   <= out_skip_in;
      out_last_ff   <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[frame_waddr] <= wdata;
      end
      frame_rd_ff <= frame_mem[frame_raddr];
   end

   always_ff @(posedge clock) begin
      if (slice_we) begin
         slice_mem[slice_waddr] <= wdata;
      end
      slice_rd_ff <= slice_mem[slice_raddr];
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_skip  = out_skip_ff;
   assign out_last  = out_last_ff;

   `TSP_ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, (frame_fill_ff <= FW'(RING_DEPTH)) && (slice_fill_ff <= FW'(RING_DEPTH)))
   `TSP_ASSERT_IMPLY(a_idle_flushed, clock, reset, state_ff == S_IDLE, !pend_valid_ff)
   `TSP_ASSERT_IMPLY(a_no_pairs_unaligned, clock, reset, !aligned_ff, pair_count_ff == 32'd0)
   `TSP_ASSERT_IMPLY(a_result_limit, clock, reset, 1'b1, n_ff <= NW'(MAX_RESULTS))
   `TSP_ASSERT_NEXT(a_emit_loads, clock, reset, (state_ff == S_EMIT) && emit_go, pend_valid_ff)

endmodule

// File: rtl/timestamp_stream_pairing.sv
// top level: register port, input queue and pairing engine
// a beat enters the queue; the engine takes it into a ring, then runs bootstrap until aligned,
//   then forms pairs one at a time, scanning the slice entries past the head for each
// a pair leaves once the next pair of the same beat is formed or the beat's work ends
// the engine takes a new beat only once it is back in idle, the queue holding up to two beats
//   meanwhile; the slice scan is sequential. reset: synchronous, clears pointers and control state
module timestamp_stream_pairing import tsp_pkg::*; #(
   parameter int RING_DEPTH = 16,
   parameter int TIME_BITS  = 48
) (
   input  logic clock,
   input  logic reset,
   // input stream
   input  logic req_tvalid,
   output logic req_tready,
   // device_ts, depth_ts, end_ts, host_ts, tag from bit 0 up, zero padded
   input  logic [((4*TIME_BITS+32+7)/8)*8-1:0] req_tdata,
   // op: 0 colour frame, 1 event slice
   input  logic req_tuser,
   // result stream
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // color_tag, event_tag, frame_ts, event_ts, slice_stop, start_gap, offset_used,
   // mapped_color, mapped_depth, pair_seq from bit 0 up, zero padded
   output logic [((96+3*TIME_BITS+4*(TIME_BITS+2)+7)/8)*8-1:0] rsp_tdata,
   // frame_skip
   output logic rsp_tuser,
   // last_pair
   output logic rsp_tlast,
   // register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   localparam int T     = TIME_BITS;
   localparam int IDW   = 4 * T + 32;
   localparam int IPW   = ((IDW + 7) / 8) * 8;
   localparam int PDW   = 96 + 3 * T + 4 * (T + 2);
   localparam int OPW   = ((PDW + 7) / 8) * 8;

   cfg_type     cfg_ff, cfg_in;
   logic [2:0]  reg_idx;
   logic        csr_write;

   logic          q_valid, q_ready, q_op;
   logic [T-1:0]  q_device, q_aux, q_host;
   logic [31:0]   q_tag;
   logic [PDW-1:0] out_data;

   // register file
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_idx)
            REG_PHASE_THRESHOLD: cfg_in.phase_threshold = csr_pwdata;
            REG_FRAME_INTERVAL:  cfg_in.frame_interval  = csr_pwdata[19:0];
            REG_DRIFT_SHIFT:     cfg_in.drift_shift     = csr_pwdata[4:0];
            REG_MIN_SAMPLES:     cfg_in.min_samples     = csr_pwdata[4:0];
            REG_LEAD_CAP:        cfg_in.lead_cap        = csr_pwdata[4:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PHASE_THRESHOLD: csr_prdata = cfg_ff.phase_threshold;
         REG_FRAME_INTERVAL:  csr_prdata = {12'd0, cfg_ff.frame_interval};
         REG_DRIFT_SHIFT:     csr_prdata = {27'd0, cfg_ff.drift_shift};
         REG_MIN_SAMPLES:     csr_prdata = {27'd0, cfg_ff.min_samples};
         REG_LEAD_CAP:        csr_prdata = {27'd0, cfg_ff.lead_cap};
         default:             csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_threshold <= RST_PHASE_THRESHOLD;
         cfg_ff.frame_interval  <= RST_FRAME_INTERVAL;
         cfg_ff.drift_shift     <= RST_DRIFT_SHIFT;
         cfg_ff.min_samples     <= RST_MIN_SAMPLES;
         cfg_ff.lead_cap        <= RST_LEAD_CAP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: two-entry queue so the next beat is taken while the engine works
   tsp_front #(
      .TIME_BITS (T)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_tuser),
      .in_device (req_tdata[T-1:0]),
      .in_depth  (req_tdata[2*T-1:T]),
      .in_end    (req_tdata[3*T-1:2*T]),
      .in_host   (req_tdata[4*T-1:3*T]),
      .in_tag    (req_tdata[4*T+31:4*T]),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_op      (q_op),
      .q_device  (q_device),
      .q_aux     (q_aux),
      .q_host    (q_host),
      .q_tag     (q_tag)
   );

   // back: rings, alignment and pairing, result register toward the output
   tsp_engine #(
      .RING_DEPTH (RING_DEPTH),
      .TIME_BITS  (T)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_op      (q_op),
      .q_device  (q_device),
      .q_aux     (q_aux),
      .q_host    (q_host),
      .q_tag     (q_tag),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data),
      .out_skip  (rsp_tuser),
      .out_last  (rsp_tlast)
   );

   // byte padding of the result beat
   if (OPW > PDW) begin : g_pad
      assign rsp_tdata = {{(OPW-PDW){1'b0}}, out_data};
   end else begin : g_nopad
      assign rsp_tdata = out_data;
   end

   // pad bits of the input beat carry nothing
   logic unused_pad;
   if (IPW > IDW) begin : g_in_pad
      assign unused_pad = ^req_tdata[IPW-1:IDW];
   end else begin : g_in_nopad
      assign unused_pad = 1'b0;
   end

endmodule

// File: tb/tsp_pair_checker.sv
// pairing checker: watches the channels and register port, predicts pairs and compares them
module tsp_pair_checker import tsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [223:0] req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [439:0] rsp_tdata,
   input  logic         rsp_tuser,
   input  logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic         csr_pready,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output int           pending_pairs,
   output int           mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;

   typedef struct {
      logic [31:0] color_tag, event_tag;
      logic [47:0] frame_ts, event_ts, slice_stop;
      logic [49:0] start_gap, offset_used, mapped_color, mapped_depth;
      logic [31:0] pair_seq;
      logic        frame_skip, last_pair;
   } pair_type;

   pair_type expected_pairs[$];
   cfg_type cfg;

   logic [47:0] f_time[DEPTH], f_depth[DEPTH], f_host[DEPTH];
   logic [31:0] f_tag[DEPTH];
   logic [47:0] s_start[DEPTH], s_end[DEPTH], s_host[DEPTH];
   logic [31:0] s_tag[DEPTH];
   int          f_head, f_fill, s_head, s_fill;
   bit          aligned, skip_flag;
   longint      offset;
   logic [31:0] pair_count;

   assign pending_pairs = expected_pairs.size();

   function automatic longint wrap50(longint v);
      return {{14{v[49]}}, v[49:0]};
   endfunction

   function automatic longint host_val(logic [47:0] h);
      return {{16{h[47]}}, h};
   endfunction

   function automatic longint abs_dist(longint a, longint b);
      return (a - b) < 0 ? b - a : a - b;
   endfunction

   function automatic int fi(int i);
      return (f_head + i) % DEPTH;
   endfunction

   function automatic int si(int i);
      return (s_head + i) % DEPTH;
   endfunction

   function automatic void frame_drop();
      if (f_fill > 0) begin
         f_head = (f_head + 1) % DEPTH;
         f_fill--;
      end
   endfunction

   function automatic void slice_drop();
      if (s_fill > 0) begin
         s_head = (s_head + 1) % DEPTH;
         s_fill--;
      end
   endfunction

   // returns 1 once the clocks are aligned
   function automatic bit try_align();
      int     need;
      longint phase;
      need = (cfg.min_samples == 0) ? 1 : int'(cfg.min_samples);
      if (f_fill < need || s_fill < need) return 0;
      if (host_val(f_host[fi(0)]) <= 0 || host_val(s_host[si(0)]) <= 0) return 0;
      phase = host_val(f_host[fi(0)]) - host_val(s_host[si(0)]);
      if (phase < longint'($signed(cfg.phase_threshold))) begin
         if (f_fill < 2) return 0;
         frame_drop();
         skip_flag = 1;
      end else begin
         skip_flag = 0;
      end
      if (f_fill == 0) return 0;
      offset = wrap50(longint'({16'b0, s_start[si(0)]}) - longint'({16'b0, f_time[fi(0)]}));
      aligned = 1;
      return 1;
   endfunction

   function automatic void pair_beat(logic [223:0] d, logic is_slice);
      pair_type made[$];
      pair_type r;
      int     p, best, f, s;
      longint used, mapped, bestd, span_d, diff, stepv, start;
      if (!is_slice) begin
         if (f_fill >= DEPTH) frame_drop();
         p = fi(f_fill);
         f_time[p] = d[47:0];
         f_depth[p] = d[95:48];
         f_host[p] = d[191:144];
         f_tag[p] = d[223:192];
         f_fill++;
      end else begin
         if (s_fill >= DEPTH) slice_drop();
         p = si(s_fill);
         s_start[p] = d[47:0];
         s_end[p] = d[143:96];
         s_host[p] = d[191:144];
         s_tag[p] = d[223:192];
         s_fill++;
      end
      if (!aligned && !try_align()) return;

      while (f_fill > 0 && s_fill > 0 && made.size() < MAX_RESULTS) begin
         f = fi(0);
         used = offset;
         mapped = longint'({16'b0, f_time[f]}) + used;
         bestd = abs_dist({16'b0, s_start[si(0)]}, mapped);
         best = 0;
         // forward scan while the slices get closer to the mapped time
         for (int i = 1; i < s_fill; i++) begin
            span_d = abs_dist({16'b0, s_start[si(i)]}, mapped);
            if (span_d < bestd) begin
               bestd = span_d;
               best = i;
            end else begin
               break;
            end
         end
         if (best == s_fill - 1 &&
             longint'({16'b0, s_start[si(best)]}) > mapped + longint'(cfg.frame_interval))
            break;
         for (int i = 0; i < best; i++) slice_drop();
         s = si(0);
         start = {16'b0, s_start[s]};
         diff = start - mapped;
         stepv = diff < 0 ? -((-diff) >> cfg.drift_shift) : diff >> cfg.drift_shift;
         offset = wrap50(used + stepv);
         r.color_tag = f_tag[f];
         r.event_tag = s_tag[s];
         r.frame_ts = f_time[f];
         r.event_ts = s_start[s];
         r.slice_stop = s_end[s];
         r.start_gap = diff[49:0];
         r.offset_used = used[49:0];
         r.mapped_color = mapped[49:0];
         span_d = longint'({16'b0, f_depth[f]}) + used;
         r.mapped_depth = span_d[49:0];
         r.pair_seq = pair_count;
         r.frame_skip = skip_flag;
         r.last_pair = 0;
         pair_count++;
         made.insert(made.size(), r);
         slice_drop();
         frame_drop();
      end
      if (made.size() > 0) made[made.size()-1].last_pair = 1;
      foreach (made[i]) expected_pairs.insert(expected_pairs.size(), made[i]);

      // stall guard
      if (f_fill > cfg.lead_cap && s_fill == 0) frame_drop();
      if (s_fill > cfg.lead_cap && f_fill == 0) slice_drop();
   endfunction

   function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      pair_type e;
      if (reset) begin
         f_head = 0; f_fill = 0; s_head = 0; s_fill = 0;
         aligned = 0; skip_flag = 0; offset = 0; pair_count = 0;
         cfg.phase_threshold = RST_PHASE_THRESHOLD;
         cfg.frame_interval = RST_FRAME_INTERVAL;
         cfg.drift_shift = RST_DRIFT_SHIFT;
         cfg.min_samples = RST_MIN_SAMPLES;
         cfg.lead_cap = RST_LEAD_CAP;
         expected_pairs.delete();
         mismatch_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_BITS-1:2])
               REG_PHASE_THRESHOLD: cfg.phase_threshold = csr_pwdata;
               REG_FRAME_INTERVAL:  cfg.frame_interval = csr_pwdata[19:0];
               REG_DRIFT_SHIFT:     cfg.drift_shift = csr_pwdata[4:0];
               REG_MIN_SAMPLES:     cfg.min_samples = csr_pwdata[4:0];
               REG_LEAD_CAP:        cfg.lead_cap = csr_pwdata[4:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) pair_beat(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pairs.size() == 0) begin
               $display("%0t mismatch: unexpected pair, expected none actual %h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               e = expected_pairs[0];
               expected_pairs.delete(0);
               check_field("color_tag", e.color_tag, rsp_tdata[31:0]);
               check_field("event_tag", e.event_tag, rsp_tdata[63:32]);
               check_field("frame_ts", e.frame_ts, rsp_tdata[111:64]);
               check_field("event_ts", e.event_ts, rsp_tdata[159:112]);
               check_field("slice_stop", e.slice_stop, rsp_tdata[207:160]);
               check_field("start_gap", e.start_gap, rsp_tdata[257:208]);
               check_field("offset_used", e.offset_used, rsp_tdata[307:258]);
               check_field("mapped_color", e.mapped_color, rsp_tdata[357:308]);
               check_field("mapped_depth", e.mapped_depth, rsp_tdata[407:358]);
               check_field("pair_seq", e.pair_seq, rsp_tdata[439:408]);
               check_field("frame_skip", e.frame_skip, rsp_tuser);
               check_field("last_pair", e.last_pair, rsp_tlast);
            end
         end
      end
   end

endmodule

// File: tb/tb_timestamp_stream_pairing.sv
// testbench top: stimulus, register phases, idling, watchdog and verdict
module tb_timestamp_stream_pairing;
   import tsp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 400;
   localparam longint BASE_OFFSET = 5000;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   // device_ts, depth_ts, end_ts, host_ts, tag from bit 0 up
   logic [223:0] req_tdata = '0;
   // op
   logic         req_tuser = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   // color_tag, event_tag, frame_ts, event_ts, slice_stop, start_gap, offset_used,
   // mapped_color, mapped_depth, pair_seq from bit 0 up
   logic [439:0] rsp_tdata;
   // frame_skip
   logic         rsp_tuser;
   // last_pair
   logic         rsp_tlast;
   logic         csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   int  pending_pairs, mismatch_count;
   int  send_idle_pct = 0, stall_pct = 0;
   bit  pressure_on = 0;
   int  held_cycles = 0;
   int  quiet_cycles = 0;
   longint frame_clock = 1000000;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   timestamp_stream_pairing dut (.*);

   tsp_pair_checker checker_i (.*);

   // receiver: random stalls, plus one long hold-off while pressure is on
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (pressure_on && held_cycles < HOLD_CYCLES) begin
         held_cycles <= held_cycles + 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog on cycles without any accepted beat or register access
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic send_beat(logic op, logic [47:0] dev, logic [47:0] dep,
                            logic [47:0] fin, logic [47:0] host, logic [31:0] tag);
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= {tag, host, fin, dep, dev};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // random gap, lowered only when a gap really follows
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
   endtask

   task automatic send_frame(logic [47:0] host);
      frame_clock += 33333;
      send_beat(1'b0, 48'(frame_clock), 48'(frame_clock + 100), 48'($urandom), host,
                $urandom);
   endtask

   task automatic send_slice(longint when, logic [47:0] host);
      send_beat(1'b1, 48'(when + BASE_OFFSET + $urandom_range(4000) - 2000),
                48'($urandom), 48'(when + BASE_OFFSET + 30000), host, $urandom);
   endtask

   // wait until all pairs are out, then let the engine settle
   task automatic drain();
      req_tvalid <= 0;
      while (pending_pairs != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // mostly well-formed frame/slice streams, some noise beats with random fields
   task automatic random_phase(int count);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) < 20) begin
            send_beat(1'($urandom_range(1)), 48'({$urandom, $urandom}),
                      48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                      48'({$urandom, $urandom}), $urandom);
         end else if ($urandom_range(1)) begin
            send_frame(48'($urandom_range(1000000, 1)));
            if ($urandom_range(9) != 0)
               send_slice(frame_clock, 48'($urandom_range(1000000, 1)));
         end else begin
            if ($urandom_range(9) != 0) send_slice(frame_clock + 33333, 48'd5);
            send_frame(48'($urandom_range(1000000, 1)));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: skip forced by largest threshold, oldest frame with unknown host
      csr_write(REG_PHASE_THRESHOLD, 32'h7FFF_FFFF);
      csr_write(REG_MIN_SAMPLES, 32'd2);
      send_beat(1'b0, 48'(frame_clock), 48'hFFFF_FFFF_FFFF, 48'h0, 48'h8000_0000_0000,
                32'h0);
      send_slice(frame_clock + 33333, 48'h7FFF_FFFF_FFFF);
      send_slice(frame_clock + 66666, 48'd10);
      // sixteen more frames push the unknown-host frame out of the ring
      for (int k = 0; k < 16; k++) send_frame(k == 0 ? 48'd1 : 48'(500 + k));
      send_slice(frame_clock, 48'd7);
      send_beat(1'b1, 48'hFFFF_FFFF_FFFF, '0, 48'hFFFF_FFFF_FFFF, 48'd1, 32'hFFFF_FFFF);
      drain();

      // phase 0: no idling, extreme settings, long receiver hold-off
      csr_write(REG_PHASE_THRESHOLD, 32'h8000_0000);
      csr_write(REG_FRAME_INTERVAL, 32'd1000000);
      csr_write(REG_DRIFT_SHIFT, 32'd0);
      csr_write(REG_MIN_SAMPLES, 32'd16);
      csr_write(REG_LEAD_CAP, 32'd16);
      pressure_on <= 1;
      random_phase(25);
      drain();

      // phase 1: sender mostly idle, other extremes
      csr_write(REG_FRAME_INTERVAL, 32'd0);
      csr_write(REG_DRIFT_SHIFT, 32'd31);
      csr_write(REG_MIN_SAMPLES, 32'd2);
      csr_write(REG_LEAD_CAP, 32'd0);
      send_idle_pct = 81;
      random_phase(25);
      drain();

      // phase 2: receiver mostly stalled, reset-like settings
      csr_write(REG_FRAME_INTERVAL, 32'd33333);
      csr_write(REG_DRIFT_SHIFT, 32'd5);
      csr_write(REG_LEAD_CAP, 32'd8);
      send_idle_pct = 0;
      stall_pct = 81;
      random_phase(25);
      drain();

      // phase 3: light idling on both sides, random settings
      csr_write(REG_FRAME_INTERVAL, $urandom_range(1000000));
      csr_write(REG_DRIFT_SHIFT, $urandom_range(31));
      csr_write(REG_LEAD_CAP, $urandom_range(16));
      send_idle_pct = 6;
      stall_pct = 6;
      random_phase(25);
      drain();

      if (mismatch_count == 0 && pending_pairs == 0) begin
         $display("== PASS ==");
      end else begin
         if (pending_pairs != 0)
            $display("%0t mismatch: %0d pairs expected, none arrived", $time, pending_pairs);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/tsp_pkg.sv
rtl/tsp_front.sv
rtl/tsp_engine.sv
rtl/timestamp_stream_pairing.sv
tb/tsp_pair_checker.sv
tb/tb_timestamp_stream_pairing.sv
